// ===== design/distance_frame_parser_with_validity_defines.svh =====
// Assertion macros shared by the distance frame parser modules.
`ifndef DISTANCE_FRAME_PARSER_WITH_VALIDITY_DEFINES_SVH
`define DISTANCE_FRAME_PARSER_WITH_VALIDITY_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define DFPV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dfpv assertion failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define DFPV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dfpv assertion failed");

`endif

// ===== design/dfpv_pkg.sv =====
// Types and constants for the distance frame parser.
package dfpv_pkg;

  localparam logic [7:0] FrameHeader = 8'hFF;
  localparam int unsigned FrameLen = 4;
  localparam int unsigned PosW = $clog2(FrameLen);

  localparam logic [7:0]  StaleLimitRst  = 8'd50;
  localparam logic [15:0] JumpLimitRst   = 16'd50;
  localparam logic [15:0] MinDistanceRst = 16'd10;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned StaleW   = 9;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStaleLimit  = 2'd0,
    CfgJumpLimit   = 2'd1,
    CfgMinDistance = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // What one byte did to the frame.
  typedef struct packed {
    logic        done;        // byte sat in the checksum slot
    logic        good;        // header and checksum matched
    logic [15:0] frame_dist;  // distance carried by the frame
  } frm_evt_t;

endpackage

// ===== design/distance_frame_parser_with_validity.sv =====
// Top level of the ultrasonic distance frame parser with validity tracking.
//
// Input channel: one received serial byte per request (in_valid_i, rx_byte_i),
// held off by in_stall_o. Each byte gives exactly one result on the output
// channel (out_valid_o, distance_o, distance_valid_o, frame_accepted_o), which
// the receiver holds off with out_stall_i.
// A byte of 0xFF restarts the frame; a four-byte frame with a good checksum
// loads a new distance and raises frame_accepted_o for that byte.
// A byte's result is on the outputs in the cycle after it is taken.
// Throughput: one byte per cycle unless stalled; the frame and tracker state
// update in the same cycle the byte is taken, feeding the single result
// register. While the result register is full and stalled, in_stall_o is high
// and no byte is taken; a byte is taken in the same cycle the old result leaves.
// Reset clears the frame position and bytes, the distance, the valid flag and
// the stale count, loads the limit registers with their defaults (stale 50,
// jump 50, minimum 10) and empties the result register.
// Limits are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle.
`include "distance_frame_parser_with_validity_defines.svh"

module distance_frame_parser_with_validity
  import dfpv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         distance_o,
  output logic                distance_valid_o,
  output logic                frame_accepted_o
);

  cfg_wr_t     cfg;
  frm_evt_t    evt;
  logic        step;
  logic [15:0] dist_d, dist_q;
  logic        valid_d, valid_q, acc_q;
  logic        ovld_q, ovld_d;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  assign in_stall_o = ovld_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  dfpv_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (rx_byte_i),
    .evt_o     (evt)
  );

  dfpv_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (step),
    .evt_i     (evt),
    .dist_d_o  (dist_d),
    .valid_d_o (valid_d)
  );

  assign ovld_d = step || (ovld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      dist_q  <= dist_d;
      valid_q <= valid_d;
      acc_q   <= evt.good;
    end
  end

  assign out_valid_o      = ovld_q;
  assign distance_o       = dist_q;
  assign distance_valid_o = valid_q;
  assign frame_accepted_o = acc_q;

  `DFPV_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_o)
  `DFPV_ASSERT_NEXT(a_request_gives_result, step, out_valid_o)
  `DFPV_ASSERT_NEXT(a_drain_empties, out_valid_o && !out_stall_i && !step, !out_valid_o)

endmodule

// ===== design/dfpv_frame.sv =====
// Frame assembler: byte position, stored frame bytes and checksum check.
module dfpv_frame
  import dfpv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  output frm_evt_t   evt_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]      hdr_q, hi_q, lo_q;
  logic [7:0]      sum;

  // A header byte restarts the frame, even in the checksum slot.
  assign pos_eff = (rx_byte_i == FrameHeader) ? '0 : pos_q;
  assign sum     = hdr_q + hi_q + lo_q;

  always_comb begin
    evt_o.done       = (pos_eff == PosW'(FrameLen - 1));
    evt_o.good       = evt_o.done && (hdr_q == FrameHeader) && (sum == rx_byte_i);
    evt_o.frame_dist = {hi_q, lo_q};
    pos_d            = evt_o.done ? '0 : pos_eff + PosW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= '0;
      hi_q  <= '0;
      lo_q  <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      if (pos_eff == PosW'(0)) hdr_q <= rx_byte_i;
      if (pos_eff == PosW'(1)) hi_q  <= rx_byte_i;
      if (pos_eff == PosW'(2)) lo_q  <= rx_byte_i;
    end
  end

endmodule

// ===== design/dfpv_track.sv =====
// Validity tracker: stored distance, valid flag, stale counter and limits.
`include "distance_frame_parser_with_validity_defines.svh"

module dfpv_track
  import dfpv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_i,
  input  logic        step_i,
  input  frm_evt_t    evt_i,
  output logic [15:0] dist_d_o,
  output logic        valid_d_o
);

  logic [7:0]        stale_lim_q;
  logic [15:0]       jump_lim_q, min_dist_q;
  logic [15:0]       dist_q, dist_d;
  logic              valid_q, valid_d, valid_mid;
  logic [StaleW-1:0] stale_q, stale_d, stale_inc;
  logic [15:0]       rise;
  logic              jump_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_lim_q <= StaleLimitRst;
      jump_lim_q  <= JumpLimitRst;
      min_dist_q  <= MinDistanceRst;
    end else if (cfg_i.we) begin
      case (cfg_idx_e'(cfg_i.idx))
        CfgStaleLimit:  stale_lim_q <= cfg_i.data[7:0];
        CfgJumpLimit:   jump_lim_q  <= cfg_i.data;
        CfgMinDistance: min_dist_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign dist_d    = evt_i.good ? evt_i.frame_dist : dist_q;
  // bad frame clears the flag before the tracker looks at it
  assign valid_mid = (evt_i.done && !evt_i.good) ? 1'b0 : valid_q;
  assign stale_inc = stale_q + StaleW'(1);
  assign rise      = dist_d - dist_q;
  assign jump_hit  = (dist_d > dist_q) && (rise > jump_lim_q);

  always_comb begin
    stale_d = stale_q;
    valid_d = valid_mid;
    if (dist_d == dist_q) begin
      stale_d = stale_inc;
      if (stale_inc > {1'b0, stale_lim_q}) begin
        valid_d = 1'b0;
        stale_d = '0;
      end
    end else if (valid_q && jump_hit) begin
      valid_d = 1'b0;
    end else if (dist_d < min_dist_q) begin
      valid_d = 1'b0;
    end else begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= '0;
      valid_q <= 1'b0;
      stale_q <= '0;
    end else if (step_i) begin
      dist_q  <= dist_d;
      valid_q <= valid_d;
      stale_q <= stale_d;
    end
  end

  assign dist_d_o  = dist_d;
  assign valid_d_o = valid_d;

  `DFPV_ASSERT_NOW(a_stale_bound, 1'b1, stale_q <= StaleW'(256))
  `DFPV_ASSERT_NEXT(a_bad_frame_clears, step_i && evt_i.done && !evt_i.good, !valid_q)
  `DFPV_ASSERT_NEXT(a_below_min_clears,
    step_i && evt_i.good && (evt_i.frame_dist != dist_q) && (evt_i.frame_dist < min_dist_q),
    !valid_q)
  `DFPV_ASSERT_NEXT(a_idle_holds, !step_i, $stable(dist_q) && $stable(valid_q))

endmodule

// ===== tb/testbench.sv =====
// Testbench for the distance frame parser: directed frames, limit extremes, random traffic.
`timescale 1ns / 1ps

module testbench;
  import dfpv_pkg::*;

  typedef struct {
    logic [15:0] distance;
    logic        ok;
    logic        acc;
  } reading_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [15:0]         distance_o;
  logic                distance_valid_o;
  logic                frame_accepted_o;

  distance_frame_parser_with_validity u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .distance_o      (distance_o),
    .distance_valid_o(distance_valid_o),
    .frame_accepted_o(frame_accepted_o)
  );

  // Local copy of the parser and tracker state
  int unsigned       m_pos;
  logic [7:0]        m_bytes [3];
  logic [15:0]       m_dist;
  logic              m_valid;
  logic [StaleW-1:0] m_stale;
  logic [7:0]        m_stale_lim;
  logic [15:0]       m_jump;
  logic [15:0]       m_min;

  reading_t pending_readings[$];
  reading_t want_r;

  int tx_max_gap = 0;
  int rx_max_gap = 0;
  int rx_hold    = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_frames   = 0;
  int n_valid_hi = 0;
  int err_cnt    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[distance_frame_parser_with_validity] ERROR");
    $finish;
  end

  function automatic int draw_wait(input int max_gap);
    return (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
  endfunction

  function automatic void reset_model();
    m_pos       = 0;
    m_bytes     = '{default: 8'h00};
    m_dist      = '0;
    m_valid     = 1'b0;
    m_stale     = '0;
    m_stale_lim = StaleLimitRst;
    m_jump      = JumpLimitRst;
    m_min       = MinDistanceRst;
  endfunction

  // Advance the parser and tracker by one byte and queue the reading it yields
  function automatic void track_byte(input logic [7:0] b);
    logic [15:0] prev_d;
    logic        prev_v;
    logic [7:0]  sum;
    int          rise;
    reading_t    r;
    prev_d = m_dist;
    prev_v = m_valid;
    r.acc  = 1'b0;
    if (b == FrameHeader) m_pos = 0;
    if (m_pos < FrameLen - 1) begin
      m_bytes[m_pos] = b;
      m_pos++;
    end else begin
      sum = m_bytes[0] + m_bytes[1] + m_bytes[2];
      if (m_bytes[0] == FrameHeader && sum == b) begin
        m_dist = {m_bytes[1], m_bytes[2]};
        r.acc  = 1'b1;
      end else begin
        m_valid = 1'b0;
      end
      m_pos = 0;
    end
    rise = int'(m_dist) - int'(prev_d);
    if (m_dist == prev_d) begin
      m_stale = m_stale + 1'b1;
      if (m_stale > m_stale_lim) begin
        m_valid = 1'b0;
        m_stale = '0;
      end
    end else if (prev_v && rise > int'(m_jump)) begin
      m_valid = 1'b0;
    end else if (m_dist < m_min) begin
      m_valid = 1'b0;
    end else begin
      m_valid = 1'b1;
    end
    r.distance = m_dist;
    r.ok       = m_valid;
    pending_readings.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
    err_cnt++;
  endtask

  // Valid stays high on return so back-to-back requests need no gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(tx_max_gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    track_byte(b);
    n_sent++;
  endtask

  task automatic send_frame(input logic [15:0] d, input bit corrupt);
    logic [7:0] sum;
    sum = FrameHeader + d[15:8] + d[7:0];
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    send_byte(FrameHeader);
    send_byte(d[15:8]);
    send_byte(d[7:0]);
    send_byte(sum);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    in_valid_i  = 1'b0;
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgStaleLimit:  m_stale_lim = val[7:0];
      CfgJumpLimit:   m_jump      = val;
      CfgMinDistance: m_min       = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_limit(input int near_max);
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, near_max));
      default: return 16'($urandom);
    endcase
  endfunction

  // Good frames, small rise, large jump, bad checksum, bad header,
  // 0xFF in the checksum slot, distance below minimum
  task automatic test_frame_basics();
    tx_max_gap = 3;
    rx_max_gap = 3;
    send_frame(16'h1234, 1'b0);
    send_frame(16'h1260, 1'b0);
    send_frame(16'h2000, 1'b0);
    send_frame(16'h2000, 1'b1);
    send_byte(8'h00);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h46);
    // checksum of FF,10,F0 is FF itself, so that frame restarts
    send_byte(FrameHeader);
    send_byte(8'h10);
    send_byte(8'hF0);
    send_byte(FrameHeader);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'h04);
    drain_results();
  endtask

  task automatic test_limit_extremes();
    tx_max_gap = 18;
    rx_max_gap = 18;
    cfg_write(CfgStaleLimit, 16'd0);
    cfg_write(CfgJumpLimit, 16'd0);
    cfg_write(CfgMinDistance, 16'd0);
    send_frame(16'h0000, 1'b0);
    send_frame(16'h0001, 1'b0);
    send_byte(8'h00);
    drain_results();
    cfg_write(CfgStaleLimit, 16'd255);
    cfg_write(CfgJumpLimit, 16'hFFFF);
    cfg_write(CfgMinDistance, 16'hFFFF);
    send_frame(16'hFEFE, 1'b0);
    send_frame(16'h0000, 1'b0);
    drain_results();
    cfg_write(CfgMinDistance, 16'd0);
    send_frame(16'hFEFE, 1'b0);
    send_frame(16'hFEFD, 1'b0);
    send_frame(16'hFEFE, 1'b0);
    drain_results();
    cfg_write(CfgJumpLimit, 16'd0);
    send_frame(16'hFEFD, 1'b0);
    send_frame(16'hFEFE, 1'b0);
    drain_results();
    cfg_write(CfgStaleLimit, 16'(StaleLimitRst));
    cfg_write(CfgJumpLimit, JumpLimitRst);
    cfg_write(CfgMinDistance, MinDistanceRst);
  endtask

  // Stale count running up to its wrap, then a limit lowered under a high count
  task automatic test_stale_wrap();
    tx_max_gap = 0;
    rx_max_gap = 2;
    cfg_write(CfgStaleLimit, 16'd255);
    repeat (300) send_byte(8'h00);
    drain_results();
    repeat (100) send_byte(8'h00);
    drain_results();
    cfg_write(CfgStaleLimit, 16'd3);
    repeat (6) send_byte(8'h01);
    drain_results();
    cfg_write(CfgStaleLimit, 16'(StaleLimitRst));
  endtask

  task automatic test_random_traffic();
    int          gaps [3] = '{0, 3, 18};
    int          stop_at;
    int          kind;
    logic [15:0] d;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case ($urandom_range(0, 3))
        0:       cfg_write(CfgStaleLimit, 16'd0);
        1:       cfg_write(CfgStaleLimit, 16'd255);
        default: cfg_write(CfgStaleLimit, 16'($urandom_range(1, 12)));
      endcase
      cfg_write(CfgJumpLimit, pick_limit(100));
      cfg_write(CfgMinDistance, pick_limit(30));
      tx_max_gap = gaps[ph % 3];
      rx_max_gap = gaps[(ph / 3) % 3];
      stop_at = n_sent + 180;
      while (n_sent < stop_at) begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          case ($urandom_range(0, 4))
            0:       d = m_dist;
            1:       d = m_dist + 16'($urandom_range(0, 120));
            2:       d = m_dist - 16'($urandom_range(0, 120));
            3:       d = 16'($urandom);
            default: d = 16'($urandom_range(0, 40));
          endcase
          send_frame(d, 1'b0);
        end else if (kind < 85) begin
          send_frame(16'($urandom), 1'b1);
        end else if (kind < 95) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else begin
          // truncated frame
          send_byte(FrameHeader);
          repeat ($urandom_range(1, 2)) send_byte(8'($urandom));
        end
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i = 1'b1;
      rx_hold--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rx_hold = draw_wait(rx_max_gap);
      if (pending_readings.size() == 0) begin
        report_mismatch("result with no request outstanding", distance_o, 0);
      end else begin
        want_r = pending_readings.pop_front();
        if (distance_o !== want_r.distance)
          report_mismatch("distance", distance_o, want_r.distance);
        if (distance_valid_o !== want_r.ok)
          report_mismatch("distance_valid", distance_valid_o, want_r.ok);
        if (frame_accepted_o !== want_r.acc)
          report_mismatch("frame_accepted", frame_accepted_o, want_r.acc);
        n_checked++;
        n_frames   += want_r.acc;
        n_valid_hi += want_r.ok;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgStaleLimit;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_stall_i = 1'b0;
    reset_model();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_frame_basics();
    test_limit_extremes();
    test_stale_wrap();
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d results: %0d good frames, %0d readings valid.",
             n_sent, n_checked, n_frames, n_valid_hi);
    $display("Covered limit extremes, stale wrap, and random limits under idle/stall mixes.");
    if (err_cnt == 0 && pending_readings.size() == 0) begin
      $display("[distance_frame_parser_with_validity] OK");
    end else begin
      $display("[distance_frame_parser_with_validity] ERROR");
    end
    $finish;
  end

endmodule
